FILE: sv/sscp_pkg.sv
package sscp_pkg;

  localparam int unsigned BufBytes = 512;
  localparam int unsigned CountW   = $clog2(BufBytes + 1);
  localparam int unsigned IndexW   = $clog2(BufBytes);

  localparam logic [CountW-1:0] BufLimit = CountW'(BufBytes);
  localparam logic [CountW-1:0] CountOne = CountW'(1);

  localparam logic [31:0] FnvBasis = 32'd2166136261;

  localparam logic [7:0] ChLf = 8'h0a;
  localparam logic [7:0] ChCr = 8'h0d;
  // lower-case letters, compared after forcing bit 5
  localparam logic [7:0] ChP  = 8'h70;
  localparam logic [7:0] ChZ  = 8'h7a;
  localparam logic [7:0] ChA  = 8'h61;
  localparam logic [7:0] ChR  = 8'h72;
  localparam logic [7:0] CaseBit = 8'h20;

  localparam logic [3:0] StCont       = 4'd0;
  localparam logic [3:0] StSetkDone   = 4'd1;
  localparam logic [3:0] StPairDone   = 4'd2;
  localparam logic [3:0] StPing       = 4'd3;
  localparam logic [3:0] StBadFirst   = 4'd4;
  localparam logic [3:0] StBadSecond  = 4'd5;
  localparam logic [3:0] StSetkLong   = 4'd6;
  localparam logic [3:0] StFieldLong  = 4'd7;
  localparam logic [3:0] StIgnored    = 4'd8;

  localparam logic [1:0] CmdUnknown = 2'd0;
  localparam logic [1:0] CmdPing    = 2'd1;
  localparam logic [1:0] CmdAdd     = 2'd2;
  localparam logic [1:0] CmdRange   = 2'd3;

  localparam logic [1:0] TgtNone  = 2'd0;
  localparam logic [1:0] TgtSetKey = 2'd1;
  localparam logic [1:0] TgtKey   = 2'd2;
  localparam logic [1:0] TgtValue = 2'd3;

  typedef enum logic [2:0] {
    PhStart = 3'd0,
    PhCmd   = 3'd1,
    PhSetk  = 3'd2,
    PhKey   = 3'd3,
    PhValue = 3'd4
  } phase_e;

  typedef struct packed {
    phase_e              phase;
    logic [1:0]          sub_count;
    logic [1:0]          command_kind;
    logic [CountW-1:0]   set_key_count;
    logic [CountW-1:0]   pair_key_count;
    logic [CountW-1:0]   pair_value_count;
    logic [31:0]         running_hash;
    logic                halted;
  } parse_state_t;

  localparam parse_state_t ClearState = '{
    phase:            PhStart,
    sub_count:        2'd0,
    command_kind:     CmdUnknown,
    set_key_count:    '0,
    pair_key_count:   '0,
    pair_value_count: '0,
    running_hash:     32'd0,
    halted:           1'b0
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [1:0]  command;
    logic [1:0]  store_target;
    logic [8:0]  store_index;
    logic [31:0] set_key_hash;
    logic [9:0]  set_key_length;
    logic [9:0]  pair_key_length;
    logic [9:0]  pair_value_length;
  } rsp_t;

  // fnv-1a step: xor the byte, then multiply by 16777619 = 2^24 + 0x193
  function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

FILE: sv/sscp_step.sv
module sscp_step (
  input  sscp_pkg::parse_state_t state_i,
  input  sscp_pkg::req_t         req_i,
  output sscp_pkg::parse_state_t state_o,
  output sscp_pkg::rsp_t         rsp_o
);

  always_comb begin
    sscp_pkg::parse_state_t s;
    logic [7:0] b;
    logic [7:0] bl;
    logic [3:0] status;
    logic [1:0] target;
    logic [sscp_pkg::IndexW-1:0] index;
    logic [sscp_pkg::CountW-1:0] klen;
    logic [sscp_pkg::CountW-1:0] vlen;

    s      = req_i.packet_start ? sscp_pkg::ClearState : state_i;
    b      = req_i.data_byte;
    bl     = b | sscp_pkg::CaseBit;
    status = sscp_pkg::StCont;
    target = sscp_pkg::TgtNone;
    index  = '0;

    if (s.halted) begin
      status = sscp_pkg::StIgnored;
    end else begin
      unique case (s.phase)
        sscp_pkg::PhStart: begin
          if (b == sscp_pkg::ChLf) begin
            if (s.sub_count != 2'd0) begin
              s.phase     = sscp_pkg::PhCmd;
              s.sub_count = 2'd0;
            end else begin
              s.sub_count = 2'd1;
            end
          end
        end
        sscp_pkg::PhCmd: begin
          if (s.sub_count == 2'd0) begin
            if (bl == sscp_pkg::ChP) begin
              s.command_kind = sscp_pkg::CmdPing;
              status         = sscp_pkg::StPing;
              s.halted       = 1'b1;
            end else if (bl == sscp_pkg::ChZ) begin
              s.sub_count = 2'd1;
            end else begin
              status   = sscp_pkg::StBadFirst;
              s.halted = 1'b1;
            end
          end else if (s.sub_count == 2'd1) begin
            if (bl == sscp_pkg::ChA) begin
              s.command_kind = sscp_pkg::CmdAdd;
              s.sub_count    = 2'd2;
            end else if (bl == sscp_pkg::ChR) begin
              s.command_kind = sscp_pkg::CmdRange;
              s.sub_count    = 2'd2;
            end else begin
              status   = sscp_pkg::StBadSecond;
              s.halted = 1'b1;
            end
          end else if (b == sscp_pkg::ChLf) begin
            s.phase     = sscp_pkg::PhSetk;
            s.sub_count = 2'd0;
          end
        end
        sscp_pkg::PhSetk: begin
          // first line is the length line, second holds the set key
          if (s.sub_count == 2'd0) begin
            if (b == sscp_pkg::ChLf) begin
              s.sub_count = 2'd1;
            end
          end else if (b == sscp_pkg::ChCr) begin
            status = sscp_pkg::StCont;
          end else if (b == sscp_pkg::ChLf) begin
            s.phase     = sscp_pkg::PhKey;
            s.sub_count = 2'd0;
            status      = sscp_pkg::StSetkDone;
          end else if (s.set_key_count >= sscp_pkg::BufLimit) begin
            status   = sscp_pkg::StSetkLong;
            s.halted = 1'b1;
          end else begin
            target = sscp_pkg::TgtSetKey;
            index  = s.set_key_count[sscp_pkg::IndexW-1:0];
            s.running_hash = sscp_pkg::fnv_mix(
              (s.set_key_count == '0) ? sscp_pkg::FnvBasis : s.running_hash, b);
            s.set_key_count = s.set_key_count + sscp_pkg::CountOne;
          end
        end
        sscp_pkg::PhKey: begin
          if (s.pair_key_count >= sscp_pkg::BufLimit) begin
            status   = sscp_pkg::StFieldLong;
            s.halted = 1'b1;
          end else begin
            target = sscp_pkg::TgtKey;
            index  = s.pair_key_count[sscp_pkg::IndexW-1:0];
            s.pair_key_count = s.pair_key_count + sscp_pkg::CountOne;
            if (b == sscp_pkg::ChLf) begin
              if (s.sub_count == 2'd0) begin
                s.sub_count = 2'd1;
              end else begin
                s.phase     = sscp_pkg::PhValue;
                s.sub_count = 2'd0;
              end
            end
          end
        end
        sscp_pkg::PhValue: begin
          if (s.pair_value_count >= sscp_pkg::BufLimit) begin
            status   = sscp_pkg::StFieldLong;
            s.halted = 1'b1;
          end else begin
            target = sscp_pkg::TgtValue;
            index  = s.pair_value_count[sscp_pkg::IndexW-1:0];
            s.pair_value_count = s.pair_value_count + sscp_pkg::CountOne;
            if (b == sscp_pkg::ChLf) begin
              if (s.sub_count == 2'd0) begin
                s.sub_count = 2'd1;
              end else begin
                status = sscp_pkg::StPairDone;
              end
            end
          end
        end
        default: begin
          status = sscp_pkg::StIgnored;
        end
      endcase
    end

    klen = s.pair_key_count;
    vlen = s.pair_value_count;
    // lengths go out first, then the pair counters restart for the next key
    if (status == sscp_pkg::StPairDone) begin
      s.pair_key_count   = '0;
      s.pair_value_count = '0;
      s.sub_count        = 2'd0;
      s.phase            = sscp_pkg::PhKey;
    end

    state_o = s;
    rsp_o.status            = status;
    rsp_o.command           = s.command_kind;
    rsp_o.store_target      = target;
    rsp_o.store_index       = 9'(index);
    rsp_o.set_key_hash      = s.running_hash;
    rsp_o.set_key_length    = 10'(s.set_key_count);
    rsp_o.pair_key_length   = 10'(klen);
    rsp_o.pair_value_length = 10'(vlen);
  end

endmodule

FILE: sv/sorted_set_command_parser.sv
// sorted-set request parser, one request byte per request on the input channel
// in_data_i carries the byte and packet_start; packet_start clears the parser
// before that byte is handled. every accepted request yields exactly one
// result on out_data_o: status, decoded command, where the byte is stored
// (set key, pair key or pair value buffer) with its index, the running
// fnv-1a 32 hash of the set key and the field lengths.
// the result register loads at the edge that accepts the request. throughput is
// one request per cycle while the receiver keeps up; parser state and the
// result are updated by a single combinational pass between them.
// when the receiver stalls, the result register holds and in_ready_o drops
// until the result is taken; a request is still taken in the same cycle the
// waiting result leaves.
// after ping, a bad command byte or an overflow the parser reports every byte
// as ignored until the next packet start.
// reset clears the parser to the start state and empties the result register.
module sorted_set_command_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sscp_pkg::req_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sscp_pkg::rsp_t   out_data_o
);

  sscp_pkg::parse_state_t state_q, state_d;
  sscp_pkg::rsp_t         rsp_q, rsp_d;
  logic                   out_valid_q;
  logic                   in_fire;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  sscp_step u_step (
    .state_i (state_q),
    .req_i   (in_data_i),
    .state_o (state_d),
    .rsp_o   (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sscp_pkg::ClearState;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rsp_q <= rsp_d;
    end
  end

  a_halt_ignores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && state_q.halted && !in_data_i.packet_start
    |=> out_valid_q && rsp_q.status == sscp_pkg::StIgnored)
    else $error("halted parser did not ignore byte");

  a_setkey_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rsp_q.store_target == sscp_pkg::TgtSetKey
    |-> rsp_q.store_index == 9'(rsp_q.set_key_length - 10'd1))
    else $error("set key index out of step with length");

  a_pair_done_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rsp_q.status == sscp_pkg::StPairDone
    |-> rsp_q.store_target == sscp_pkg::TgtValue && state_q.phase == sscp_pkg::PhKey)
    else $error("pair complete without value byte or key restart");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(state_q))
    else $error("parser state moved without a request");

endmodule

FILE: verif/tb_sorted_set_command_parser.sv
module tb_sorted_set_command_parser;

  localparam logic [31:0] FnvPrime = 32'd16777619;
  localparam int unsigned BytesWanted = 1200;
  localparam int unsigned HoldCycles = 300;

  typedef struct {
    sscp_pkg::req_t req;
    bit             typed;
    sscp_pkg::rsp_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  sscp_pkg::req_t in_data = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  sscp_pkg::rsp_t out_data_o;

  // parser state as seen by the predictor
  sscp_pkg::phase_e prs_phase;
  int unsigned prs_sub;
  logic [1:0]  prs_cmd;
  int unsigned prs_setk;
  int unsigned prs_key;
  int unsigned prs_val;
  logic [31:0] prs_hash;
  bit          prs_halt;

  sscp_pkg::rsp_t pending_rsp[$];
  stim_row_t   script[$];
  logic [7:0]  pkt_bytes[$];
  int unsigned mismatches = 0;
  int unsigned sent_items = 0;
  bit          idle_on = 1'b1;
  bit          hold_off_req = 1'b0;

  sorted_set_command_parser uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void clear_parser();
    prs_phase = sscp_pkg::PhStart;
    prs_sub = 0;
    prs_cmd = sscp_pkg::CmdUnknown;
    prs_setk = 0;
    prs_key = 0;
    prs_val = 0;
    prs_hash = 32'd0;
    prs_halt = 1'b0;
  endfunction

  function automatic sscp_pkg::rsp_t rsp_of(input logic [3:0] st, input logic [1:0] cmd,
                                            input logic [1:0] tgt, input int idx,
                                            input logic [31:0] h, input int sl,
                                            input int kl, input int vl);
    sscp_pkg::rsp_t o;
    o.status = st;
    o.command = cmd;
    o.store_target = tgt;
    o.store_index = idx[8:0];
    o.set_key_hash = h;
    o.set_key_length = sl[9:0];
    o.pair_key_length = kl[9:0];
    o.pair_value_length = vl[9:0];
    return o;
  endfunction

  // advances the parser by one request byte and returns the result it reports
  function automatic sscp_pkg::rsp_t parse_byte(input sscp_pkg::req_t r);
    logic [7:0]  b;
    logic [3:0]  st;
    logic [1:0]  tgt;
    int unsigned idx;
    int unsigned klen;
    int unsigned vlen;
    b = r.data_byte;
    st = sscp_pkg::StCont;
    tgt = sscp_pkg::TgtNone;
    idx = 0;
    if (r.packet_start) clear_parser();
    if (prs_halt) begin
      st = sscp_pkg::StIgnored;
    end else begin
      case (prs_phase)
        sscp_pkg::PhStart: begin
          if (b == sscp_pkg::ChLf) begin
            prs_sub++;
            if (prs_sub >= 2) begin
              prs_phase = sscp_pkg::PhCmd;
              prs_sub = 0;
            end
          end
        end
        sscp_pkg::PhCmd: begin
          if (prs_sub == 0) begin
            if (b == "p" || b == "P") begin
              prs_cmd = sscp_pkg::CmdPing;
              st = sscp_pkg::StPing;
              prs_halt = 1'b1;
            end else if (b == "z" || b == "Z") begin
              prs_sub = 1;
            end else begin
              st = sscp_pkg::StBadFirst;
              prs_halt = 1'b1;
            end
          end else if (prs_sub == 1) begin
            if (b == "a" || b == "A") begin
              prs_cmd = sscp_pkg::CmdAdd;
              prs_sub = 2;
            end else if (b == "r" || b == "R") begin
              prs_cmd = sscp_pkg::CmdRange;
              prs_sub = 2;
            end else begin
              st = sscp_pkg::StBadSecond;
              prs_halt = 1'b1;
            end
          end else if (b == sscp_pkg::ChLf) begin
            prs_phase = sscp_pkg::PhSetk;
            prs_sub = 0;
          end
        end
        sscp_pkg::PhSetk: begin
          if (prs_sub == 0) begin
            if (b == sscp_pkg::ChLf) prs_sub = 1;
          end else if (b != sscp_pkg::ChCr) begin
            if (b == sscp_pkg::ChLf) begin
              prs_phase = sscp_pkg::PhKey;
              prs_sub = 0;
              st = sscp_pkg::StSetkDone;
            end else if (prs_setk >= sscp_pkg::BufBytes) begin
              st = sscp_pkg::StSetkLong;
              prs_halt = 1'b1;
            end else begin
              // first key byte seeds the hash
              if (prs_setk == 0) prs_hash = sscp_pkg::FnvBasis;
              tgt = sscp_pkg::TgtSetKey;
              idx = prs_setk;
              prs_setk++;
              prs_hash = (prs_hash ^ {24'd0, b}) * FnvPrime;
            end
          end
        end
        sscp_pkg::PhKey: begin
          if (prs_key >= sscp_pkg::BufBytes) begin
            st = sscp_pkg::StFieldLong;
            prs_halt = 1'b1;
          end else begin
            tgt = sscp_pkg::TgtKey;
            idx = prs_key;
            prs_key++;
            if (b == sscp_pkg::ChLf) begin
              if (prs_sub == 0) begin
                prs_sub = 1;
              end else begin
                prs_phase = sscp_pkg::PhValue;
                prs_sub = 0;
              end
            end
          end
        end
        sscp_pkg::PhValue: begin
          if (prs_val >= sscp_pkg::BufBytes) begin
            st = sscp_pkg::StFieldLong;
            prs_halt = 1'b1;
          end else begin
            tgt = sscp_pkg::TgtValue;
            idx = prs_val;
            prs_val++;
            if (b == sscp_pkg::ChLf) begin
              if (prs_sub == 0) prs_sub = 1;
              else st = sscp_pkg::StPairDone;
            end
          end
        end
        default: st = sscp_pkg::StIgnored;
      endcase
    end
    klen = prs_key;
    vlen = prs_val;
    if (st == sscp_pkg::StPairDone) begin
      prs_key = 0;
      prs_val = 0;
      prs_sub = 0;
      prs_phase = sscp_pkg::PhKey;
    end
    return rsp_of(st, prs_cmd, tgt, idx, prs_hash, prs_setk, klen, vlen);
  endfunction

  task automatic send(input sscp_pkg::req_t r, input bit typed, input sscp_pkg::rsp_t want);
    int gap;
    sscp_pkg::rsp_t predicted;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready_o);
    predicted = parse_byte(r);
    sent_items++;
    pending_rsp.push_back(typed ? want : predicted);
  endtask

  task automatic row(input logic [7:0] b, input bit ps, input bit typed,
                     input sscp_pkg::rsp_t want);
    stim_row_t s;
    s.req.data_byte = b;
    s.req.packet_start = ps;
    s.typed = typed;
    s.want = want;
    script.push_back(s);
  endtask

  // stop sending and wait for every pending result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic send_packet(input bit stray_starts);
    sscp_pkg::req_t r;
    foreach (pkt_bytes[i]) begin
      r.data_byte = pkt_bytes[i];
      r.packet_start = (i == 0) || (stray_starts && $urandom_range(0, 299) == 0);
      send(r, 1'b0, '0);
    end
  endtask

  task automatic put_line(input string s);
    for (int i = 0; i < s.len(); i++) pkt_bytes.push_back(s[i]);
    pkt_bytes.push_back(sscp_pkg::ChCr);
    pkt_bytes.push_back(sscp_pkg::ChLf);
  endtask

  // payload bytes without line feeds, with an occasional carriage return mixed in when with_cr is set
  task automatic put_data(input int n, input bit with_cr);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      do b = 8'($urandom_range(0, 255)); while (b == sscp_pkg::ChLf || b == sscp_pkg::ChCr);
      pkt_bytes.push_back(b);
      if (with_cr && $urandom_range(0, 7) == 0) pkt_bytes.push_back(sscp_pkg::ChCr);
    end
  endtask

  task automatic put_header(input int n_args, input bit is_range);
    put_line($sformatf("*%0d", n_args));
    put_line(is_range ? "$14" : "$4");
    pkt_bytes.push_back($urandom_range(0, 1) ? "Z" : "z");
    if (is_range) pkt_bytes.push_back($urandom_range(0, 1) ? "R" : "r");
    else pkt_bytes.push_back($urandom_range(0, 1) ? "A" : "a");
    put_line(is_range ? "ANGEBYLEX" : "DD");
  endtask

  task automatic put_field(input int n);
    put_line($sformatf("$%0d", n));
    put_data(n, 1'b1);
    put_line("");
  endtask

  task automatic build_sorted_set();
    int n_pairs;
    int key_len;
    n_pairs = $urandom_range(1, 4);
    key_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
    pkt_bytes.delete();
    put_header(2 + 2 * n_pairs, 1'($urandom_range(0, 1)));
    put_line($sformatf("$%0d", key_len));
    put_data(key_len, 1'b1);
    put_line("");
    repeat (2 * n_pairs) put_field($urandom_range(0, 20));
  endtask

  task automatic build_ping();
    pkt_bytes.delete();
    put_line("*1");
    put_line("$4");
    pkt_bytes.push_back($urandom_range(0, 1) ? "P" : "p");
    put_line("ING");
  endtask

  task automatic build_bad_command();
    logic [7:0] b;
    pkt_bytes.delete();
    put_line("*2");
    put_line("$3");
    if ($urandom_range(0, 1)) begin
      do b = 8'($urandom_range(0, 255)); while (b == "p" || b == "P" || b == "z" || b == "Z");
    end else begin
      pkt_bytes.push_back($urandom_range(0, 1) ? "Z" : "z");
      do b = 8'($urandom_range(0, 255)); while (b == "a" || b == "A" || b == "r" || b == "R");
    end
    pkt_bytes.push_back(b);
    put_line("XX");
  endtask

  task automatic build_noise(input int n);
    pkt_bytes.delete();
    repeat (n) begin
      pkt_bytes.push_back(($urandom_range(0, 9) < 3) ? sscp_pkg::ChLf
                                                       : 8'($urandom_range(0, 255)));
    end
  endtask

  // cut the packet short and append junk
  task automatic break_packet();
    int cut;
    cut = $urandom_range(1, pkt_bytes.size());
    pkt_bytes = pkt_bytes[0:cut-1];
    repeat ($urandom_range(0, 10)) begin
      pkt_bytes.push_back(($urandom_range(0, 3) == 0) ? sscp_pkg::ChLf
                                                      : 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_rsp(input sscp_pkg::rsp_t want, input sscp_pkg::rsp_t got);
    flag_field("status", want.status, got.status);
    flag_field("command", want.command, got.command);
    flag_field("store_target", want.store_target, got.store_target);
    flag_field("store_index", want.store_index, got.store_index);
    flag_field("set_key_hash", want.set_key_hash, got.set_key_hash);
    flag_field("set_key_length", want.set_key_length, got.set_key_length);
    flag_field("pair_key_length", want.pair_key_length, got.pair_key_length);
    flag_field("pair_value_length", want.pair_value_length, got.pair_value_length);
  endtask

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing pending, expected none actual status %0d",
                 $time, out_data_o.status);
      end else begin
        check_rsp(pending_rsp.pop_front(), out_data_o);
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    int kind;
    clear_parser();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // directed: extremes, ping and range commands, errors, halting and an empty set key
    row(8'h00, 1, 1, rsp_of(sscp_pkg::StCont, sscp_pkg::CmdUnknown, sscp_pkg::TgtNone,
                            0, 0, 0, 0, 0));
    row(8'hff, 0, 1, rsp_of(sscp_pkg::StCont, sscp_pkg::CmdUnknown, sscp_pkg::TgtNone,
                            0, 0, 0, 0, 0));
    row(sscp_pkg::ChLf, 0, 1, rsp_of(sscp_pkg::StCont, sscp_pkg::CmdUnknown,
                                     sscp_pkg::TgtNone, 0, 0, 0, 0, 0));
    row(sscp_pkg::ChLf, 0, 1, rsp_of(sscp_pkg::StCont, sscp_pkg::CmdUnknown,
                                     sscp_pkg::TgtNone, 0, 0, 0, 0, 0));
    row("Q", 0, 1, rsp_of(sscp_pkg::StBadFirst, sscp_pkg::CmdUnknown, sscp_pkg::TgtNone,
                          0, 0, 0, 0, 0));
    row("Z", 0, 1, rsp_of(sscp_pkg::StIgnored, sscp_pkg::CmdUnknown, sscp_pkg::TgtNone,
                          0, 0, 0, 0, 0));
    row(sscp_pkg::ChLf, 1, 1, rsp_of(sscp_pkg::StCont, sscp_pkg::CmdUnknown,
                                     sscp_pkg::TgtNone, 0, 0, 0, 0, 0));
    row(sscp_pkg::ChLf, 0, 1, rsp_of(sscp_pkg::StCont, sscp_pkg::CmdUnknown,
                                     sscp_pkg::TgtNone, 0, 0, 0, 0, 0));
    row("P", 0, 1, rsp_of(sscp_pkg::StPing, sscp_pkg::CmdPing, sscp_pkg::TgtNone,
                          0, 0, 0, 0, 0));
    row(sscp_pkg::ChLf, 0, 1, rsp_of(sscp_pkg::StIgnored, sscp_pkg::CmdPing,
                                     sscp_pkg::TgtNone, 0, 0, 0, 0, 0));
    row(sscp_pkg::ChLf, 1, 1, rsp_of(sscp_pkg::StCont, sscp_pkg::CmdUnknown,
                                     sscp_pkg::TgtNone, 0, 0, 0, 0, 0));
    row(sscp_pkg::ChLf, 0, 1, rsp_of(sscp_pkg::StCont, sscp_pkg::CmdUnknown,
                                     sscp_pkg::TgtNone, 0, 0, 0, 0, 0));
    row("z", 0, 1, rsp_of(sscp_pkg::StCont, sscp_pkg::CmdUnknown, sscp_pkg::TgtNone,
                          0, 0, 0, 0, 0));
    row("x", 0, 1, rsp_of(sscp_pkg::StBadSecond, sscp_pkg::CmdUnknown, sscp_pkg::TgtNone,
                          0, 0, 0, 0, 0));
    row(sscp_pkg::ChLf, 1, 0, '0);
    row(sscp_pkg::ChLf, 0, 0, '0);
    row("Z", 0, 0, '0);
    row("r", 0, 0, '0);
    row(sscp_pkg::ChLf, 0, 0, '0);
    row(sscp_pkg::ChLf, 0, 0, '0);
    row(sscp_pkg::ChCr, 0, 0, '0);
    row(sscp_pkg::ChLf, 0, 1, rsp_of(sscp_pkg::StSetkDone, sscp_pkg::CmdRange,
                                     sscp_pkg::TgtNone, 0, 0, 0, 0, 0));
    row(sscp_pkg::ChLf, 0, 0, '0);
    row(sscp_pkg::ChLf, 0, 0, '0);
    row(sscp_pkg::ChLf, 0, 0, '0);
    row(sscp_pkg::ChLf, 0, 1, rsp_of(sscp_pkg::StPairDone, sscp_pkg::CmdRange,
                                     sscp_pkg::TgtValue, 1, 0, 0, 2, 2));
    foreach (script[i]) send(script[i].req, script[i].typed, script[i].want);
    drain();

    // buffer limits; the result side holds off once as the set key overflow packet starts
    idle_on = 1'b0;
    hold_off_req = 1'b1;
    pkt_bytes.delete();
    put_header(4, 1'b1);
    put_line("$600");
    put_data(sscp_pkg::BufBytes + 3, 1'b0);
    send_packet(1'b0);
    idle_on = 1'b1;
    pkt_bytes.delete();
    put_header(4, 1'b0);
    put_field(3);
    put_data(sscp_pkg::BufBytes + 1, 1'b0);
    send_packet(1'b0);
    drain();

    while (sent_items < BytesWanted) begin
      idle_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        build_sorted_set();
        if (kind >= 60) break_packet();
      end else if (kind < 78) begin
        build_ping();
      end else if (kind < 86) begin
        build_bad_command();
      end else begin
        build_noise($urandom_range(1, 30));
      end
      send_packet(1'b1);
      if ($urandom_range(0, 19) == 0) drain();
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
sv/sscp_pkg.sv
sv/sscp_step.sv
sv/sorted_set_command_parser.sv
verif/tb_sorted_set_command_parser.sv
